// ===== rtl/m4inv_pkg.sv =====
// Shared types, widths and index tables for the 4x4 matrix inverse.
`default_nettype none
package m4inv_pkg;

    localparam int ELEM_W   = 32;
    localparam int MAG_W    = 96;
    localparam int PROD_W   = 128;
    localparam int COF_W    = 98;
    localparam int ACC_W    = 132;
    localparam int QUO_W    = 33;
    localparam int DIV_LAST = 32;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_COF_INIT,
        ST_TERM_INIT,
        ST_MUL_LOAD,
        ST_MUL,
        ST_MUL_DONE,
        ST_TERM_ACC,
        ST_COF_STORE,
        ST_DET_INIT,
        ST_DET_LOAD,
        ST_DMUL,
        ST_DET_ACC,
        ST_DET_CHECK,
        ST_DIV_INIT,
        ST_DIV_PRE,
        ST_DIV,
        ST_DIV_FIN,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR_ACC,
        OP_TERM_INIT,
        OP_MUL_LOAD,
        OP_MUL_STEP,
        OP_MUL_DONE,
        OP_TERM_ACC,
        OP_COF_STORE,
        OP_DET_LOAD,
        OP_DET_ACC,
        OP_DET_CHECK,
        OP_DIV_INIT,
        OP_DIV_PRE,
        OP_DIV_STEP,
        OP_DIV_FIN
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] src_addr;
        logic [3:0] cof_addr;
        logic [1:0] chunk;
        logic       flip;
        logic [3:0] out_idx;
        logic       wr_elem;
    } cmd_t;

    typedef struct packed {
        logic singular;
    } stat_t;

    function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] k);
        logic [5:0] row;
        case (p)
            3'd0:    row = {2'd2, 2'd1, 2'd0};
            3'd1:    row = {2'd0, 2'd2, 2'd1};
            3'd2:    row = {2'd1, 2'd0, 2'd2};
            3'd3:    row = {2'd1, 2'd2, 2'd0};
            3'd4:    row = {2'd0, 2'd1, 2'd2};
            3'd5:    row = {2'd2, 2'd0, 2'd1};
            default: row = {2'd2, 2'd1, 2'd0};
        endcase
        return row[2*k +: 2];
    endfunction

    function automatic logic perm_odd(input logic [2:0] p);
        return (p >= 3'd3);
    endfunction

    function automatic logic [1:0] skip_idx(input logic [1:0] excl, input logic [1:0] k);
        return (k < excl) ? k : k + 2'd1;
    endfunction

    function automatic logic [ELEM_W-1:0] elem_mag(input logic [ELEM_W-1:0] v);
        return v[ELEM_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/matrix4x4_inverse.sv =====
// Top level of the 4x4 fixed-point matrix inverse.
`default_nettype none
// Each input beat stores one signed Q16.16 element at its row and column. A beat
// with the compute bit set also starts the inversion: the sixteen 3x3 cofactors
// are built by one 32x32 multiplier, one 32-bit chunk of each product at a time
// over three chunks; the determinant follows; then each result runs a restoring
// divider of 33 quotient bits and waits for m_tready on its output beat.
// Results leave in row-major order with tlast on the sixteenth; no input is
// taken until the last result beat has gone. A matrix whose determinant
// magnitude is below singular_limit (cfg_wr_data, reset 1) gives all zeros with
// the singular flag set.
module matrix4x4_inverse #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] element_value, [33:32] element_row, [35:34] element_col, [36] compute
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] inverse_value, [33:32] out_row, [35:34] out_col
    output logic [39:0]      m_tdata,
    // [0] singular, [1] saturated
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    m4inv_pkg::cmd_t  cmd;
    m4inv_pkg::stat_t stat;
    logic [31:0] out_value;
    logic [1:0]  out_row;
    logic [1:0]  out_col;
    logic        out_singular;
    logic        out_saturated;

    m4inv_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_compute (s_tdata[36]),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    m4inv_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_value      (s_tdata[31:0]),
        .in_row        (s_tdata[33:32]),
        .in_col        (s_tdata[35:34]),
        .cmd           (cmd),
        .stat          (stat),
        .out_value     (out_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_singular  (out_singular),
        .out_saturated (out_saturated),
        .out_last      (m_tlast)
    );

    assign m_tdata = {4'd0, out_col, out_row, out_value};
    assign m_tuser = {out_saturated, out_singular};

endmodule
`default_nettype wire

// ===== rtl/m4inv_ctrl.sv =====
// Sequencer for cofactor, determinant, division and result phases.
`default_nettype none
module m4inv_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    input  wire logic            s_compute,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output m4inv_pkg::cmd_t      cmd,
    input  wire m4inv_pkg::stat_t stat
);

    m4inv_pkg::state_t state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic [2:0] p_reg, p_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] chunk_reg, chunk_next;
    logic [5:0] cnt_reg, cnt_next;

    logic [1:0] r_idx, c_idx;
    assign r_idx = idx_reg[3:2];
    assign c_idx = idx_reg[1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= m4inv_pkg::ST_IDLE;
            idx_reg   <= '0;
            p_reg     <= '0;
            k_reg     <= '0;
            chunk_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            p_reg     <= p_next;
            k_reg     <= k_next;
            chunk_reg <= chunk_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        p_next     = p_reg;
        k_next     = k_reg;
        chunk_next = chunk_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            m4inv_pkg::ST_IDLE: begin
                if (s_tvalid && s_compute) begin
                    idx_next   = '0;
                    state_next = m4inv_pkg::ST_COF_INIT;
                end
            end
            m4inv_pkg::ST_COF_INIT: begin
                p_next     = '0;
                state_next = m4inv_pkg::ST_TERM_INIT;
            end
            m4inv_pkg::ST_TERM_INIT: begin
                k_next     = '0;
                state_next = m4inv_pkg::ST_MUL_LOAD;
            end
            m4inv_pkg::ST_MUL_LOAD: begin
                chunk_next = 2'd2;
                state_next = m4inv_pkg::ST_MUL;
            end
            m4inv_pkg::ST_MUL: begin
                if (chunk_reg == 2'd0) begin
                    state_next = m4inv_pkg::ST_MUL_DONE;
                end else begin
                    chunk_next = chunk_reg - 2'd1;
                end
            end
            m4inv_pkg::ST_MUL_DONE: begin
                if (k_reg == 2'd2) begin
                    state_next = m4inv_pkg::ST_TERM_ACC;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = m4inv_pkg::ST_MUL_LOAD;
                end
            end
            m4inv_pkg::ST_TERM_ACC: begin
                if (p_reg == 3'd5) begin
                    state_next = m4inv_pkg::ST_COF_STORE;
                end else begin
                    p_next     = p_reg + 3'd1;
                    state_next = m4inv_pkg::ST_TERM_INIT;
                end
            end
            m4inv_pkg::ST_COF_STORE: begin
                idx_next = idx_reg + 4'd1;
                if (idx_reg == 4'd15) begin
                    state_next = m4inv_pkg::ST_DET_INIT;
                end else begin
                    state_next = m4inv_pkg::ST_COF_INIT;
                end
            end
            m4inv_pkg::ST_DET_INIT: begin
                state_next = m4inv_pkg::ST_DET_LOAD;
            end
            m4inv_pkg::ST_DET_LOAD: begin
                chunk_next = 2'd2;
                state_next = m4inv_pkg::ST_DMUL;
            end
            m4inv_pkg::ST_DMUL: begin
                if (chunk_reg == 2'd0) begin
                    state_next = m4inv_pkg::ST_DET_ACC;
                end else begin
                    chunk_next = chunk_reg - 2'd1;
                end
            end
            m4inv_pkg::ST_DET_ACC: begin
                if (idx_reg[1:0] == 2'd3) begin
                    idx_next   = '0;
                    state_next = m4inv_pkg::ST_DET_CHECK;
                end else begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = m4inv_pkg::ST_DET_LOAD;
                end
            end
            m4inv_pkg::ST_DET_CHECK: begin
                state_next = m4inv_pkg::ST_DIV_INIT;
            end
            m4inv_pkg::ST_DIV_INIT: begin
                if (stat.singular) begin
                    state_next = m4inv_pkg::ST_DIV_FIN;
                end else begin
                    state_next = m4inv_pkg::ST_DIV_PRE;
                end
            end
            m4inv_pkg::ST_DIV_PRE: begin
                cnt_next   = 6'(m4inv_pkg::DIV_LAST);
                state_next = m4inv_pkg::ST_DIV;
            end
            m4inv_pkg::ST_DIV: begin
                if (cnt_reg == 6'd0) begin
                    state_next = m4inv_pkg::ST_DIV_FIN;
                end else begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            m4inv_pkg::ST_DIV_FIN: begin
                state_next = m4inv_pkg::ST_EMIT;
            end
            m4inv_pkg::ST_EMIT: begin
                if (m_tready) begin
                    idx_next = idx_reg + 4'd1;
                    if (idx_reg == 4'd15) begin
                        state_next = m4inv_pkg::ST_IDLE;
                    end else begin
                        state_next = m4inv_pkg::ST_DIV_INIT;
                    end
                end
            end
            default: begin
                state_next = m4inv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.op       = m4inv_pkg::OP_NONE;
        cmd.chunk    = chunk_reg;
        cmd.out_idx  = idx_reg;
        cmd.flip     = m4inv_pkg::perm_odd(p_reg) ^ r_idx[0] ^ c_idx[0];
        cmd.src_addr = {m4inv_pkg::skip_idx(r_idx, k_reg),
                        m4inv_pkg::skip_idx(c_idx, m4inv_pkg::perm_col(p_reg, k_reg))};
        cmd.cof_addr = idx_reg;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        case (state_reg)
            m4inv_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.wr_elem = s_tvalid;
            end
            m4inv_pkg::ST_COF_INIT:  cmd.op = m4inv_pkg::OP_CLR_ACC;
            m4inv_pkg::ST_TERM_INIT: cmd.op = m4inv_pkg::OP_TERM_INIT;
            m4inv_pkg::ST_MUL_LOAD:  cmd.op = m4inv_pkg::OP_MUL_LOAD;
            m4inv_pkg::ST_MUL:       cmd.op = m4inv_pkg::OP_MUL_STEP;
            m4inv_pkg::ST_MUL_DONE:  cmd.op = m4inv_pkg::OP_MUL_DONE;
            m4inv_pkg::ST_TERM_ACC:  cmd.op = m4inv_pkg::OP_TERM_ACC;
            m4inv_pkg::ST_COF_STORE: cmd.op = m4inv_pkg::OP_COF_STORE;
            m4inv_pkg::ST_DET_INIT:  cmd.op = m4inv_pkg::OP_CLR_ACC;
            m4inv_pkg::ST_DET_LOAD: begin
                cmd.op       = m4inv_pkg::OP_DET_LOAD;
                cmd.src_addr = {2'd0, idx_reg[1:0]};
                cmd.cof_addr = {2'd0, idx_reg[1:0]};
            end
            m4inv_pkg::ST_DMUL:      cmd.op = m4inv_pkg::OP_MUL_STEP;
            m4inv_pkg::ST_DET_ACC:   cmd.op = m4inv_pkg::OP_DET_ACC;
            m4inv_pkg::ST_DET_CHECK: cmd.op = m4inv_pkg::OP_DET_CHECK;
            m4inv_pkg::ST_DIV_INIT: begin
                cmd.op       = m4inv_pkg::OP_DIV_INIT;
                cmd.cof_addr = {idx_reg[1:0], idx_reg[3:2]};
            end
            m4inv_pkg::ST_DIV_PRE:   cmd.op = m4inv_pkg::OP_DIV_PRE;
            m4inv_pkg::ST_DIV:       cmd.op = m4inv_pkg::OP_DIV_STEP;
            m4inv_pkg::ST_DIV_FIN:   cmd.op = m4inv_pkg::OP_DIV_FIN;
            m4inv_pkg::ST_EMIT:      m_tvalid = 1'b1;
            default:                 cmd.op = m4inv_pkg::OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/m4inv_dp.sv =====
// Element store, multiply-accumulate, cofactor store and restoring divider.
`default_nettype none
module m4inv_dp #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [31:0]            cfg_wr_data,
    input  wire logic [31:0]            in_value,
    input  wire logic [1:0]             in_row,
    input  wire logic [1:0]             in_col,
    input  wire m4inv_pkg::cmd_t        cmd,
    output m4inv_pkg::stat_t            stat,
    output logic [31:0]                 out_value,
    output logic [1:0]                  out_row,
    output logic [1:0]                  out_col,
    output logic                        out_singular,
    output logic                        out_saturated,
    output logic                        out_last
);

    localparam int EW  = m4inv_pkg::ELEM_W;
    localparam int MW  = m4inv_pkg::MAG_W;
    localparam int PW  = m4inv_pkg::PROD_W;
    localparam int CW  = m4inv_pkg::COF_W;
    localparam int AW  = m4inv_pkg::ACC_W;
    localparam int QW  = m4inv_pkg::QUO_W;
    localparam int NUM_W = CW + 2 * FRACTION_BITS + 2;
    localparam int DW  = (NUM_W > AW + 34) ? NUM_W : AW + 34;

    logic [EW-1:0]        src_reg [16];
    logic [CW-1:0]        cof_reg [16];
    logic [31:0]          limit_reg;
    logic [MW-1:0]        p_reg;
    logic [PW-1:0]        pr_reg;
    logic [EW-1:0]        m_reg;
    logic                 sgn_reg;
    logic [AW-1:0]        acc_reg;
    logic                 dneg_reg;
    logic [AW-1:0]        dmag_reg;
    logic                 sing_reg;
    logic                 cneg_reg;
    logic [DW-1:0]        rem_reg;
    logic [DW-1:0]        ds_reg;
    logic [QW-1:0]        q_reg;
    logic                 big_reg;

    logic [EW-1:0]        src_rd;
    logic [CW-1:0]        cof_rd;
    logic [CW-1:0]        cof_abs;
    logic [EW-1:0]        p_chunk;
    logic [2*EW-1:0]      prod;
    logic [AW-1:0]        acc_abs;
    logic [AW-1:0]        thr;
    logic                 rem_ge;
    logic                 div_neg;
    logic [QW-1:0]        lim;
    logic                 clip;
    logic [EW-1:0]        res_mag;

    assign src_rd  = src_reg[cmd.src_addr];
    assign cof_rd  = cof_reg[cmd.cof_addr];
    assign cof_abs = cof_rd[CW-1] ? (~cof_rd + 1'b1) : cof_rd;
    assign acc_abs = acc_reg[AW-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign thr     = AW'(limit_reg) << (3 * FRACTION_BITS);
    assign rem_ge  = (rem_reg >= ds_reg);
    assign div_neg = cneg_reg ^ dneg_reg;
    assign lim     = div_neg ? QW'(33'h0_8000_0000) : QW'(33'h0_7FFF_FFFF);
    assign clip    = big_reg || (q_reg > lim);
    assign res_mag = clip ? lim[EW-1:0] : q_reg[EW-1:0];

    always_comb begin
        case (cmd.chunk)
            2'd0:    p_chunk = p_reg[EW-1:0];
            2'd1:    p_chunk = p_reg[2*EW-1:EW];
            2'd2:    p_chunk = p_reg[3*EW-1:2*EW];
            default: p_chunk = '0;
        endcase
    end

    assign prod = p_chunk * m_reg;
    assign stat.singular = sing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 32'd1;
            for (int i = 0; i < 16; i++) begin
                src_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.wr_elem) begin
                src_reg[{in_row, in_col}] <= in_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            m4inv_pkg::OP_CLR_ACC: begin
                acc_reg <= '0;
            end
            m4inv_pkg::OP_TERM_INIT: begin
                p_reg   <= MW'(1);
                sgn_reg <= cmd.flip;
            end
            m4inv_pkg::OP_MUL_LOAD: begin
                m_reg   <= m4inv_pkg::elem_mag(src_rd);
                sgn_reg <= sgn_reg ^ src_rd[EW-1];
                pr_reg  <= '0;
            end
            m4inv_pkg::OP_MUL_STEP: begin
                pr_reg <= {pr_reg[PW-EW-1:0], {EW{1'b0}}} + PW'(prod);
            end
            m4inv_pkg::OP_MUL_DONE: begin
                p_reg <= pr_reg[MW-1:0];
            end
            m4inv_pkg::OP_TERM_ACC: begin
                acc_reg <= sgn_reg ? acc_reg - AW'(p_reg) : acc_reg + AW'(p_reg);
            end
            m4inv_pkg::OP_COF_STORE: begin
                cof_reg[cmd.cof_addr] <= acc_reg[CW-1:0];
            end
            m4inv_pkg::OP_DET_LOAD: begin
                p_reg   <= cof_abs[MW-1:0];
                m_reg   <= m4inv_pkg::elem_mag(src_rd);
                sgn_reg <= cof_rd[CW-1] ^ src_rd[EW-1];
                pr_reg  <= '0;
            end
            m4inv_pkg::OP_DET_ACC: begin
                acc_reg <= sgn_reg ? acc_reg - AW'(pr_reg) : acc_reg + AW'(pr_reg);
            end
            m4inv_pkg::OP_DET_CHECK: begin
                dneg_reg <= acc_reg[AW-1];
                dmag_reg <= acc_abs;
                sing_reg <= (acc_abs == '0) || (acc_abs < thr);
            end
            m4inv_pkg::OP_DIV_INIT: begin
                cneg_reg <= cof_rd[CW-1];
                rem_reg  <= (DW'(cof_abs) << (2 * FRACTION_BITS + 1)) + DW'(dmag_reg);
                ds_reg   <= DW'(dmag_reg) << (QW + 1);
                q_reg    <= '0;
                big_reg  <= 1'b0;
            end
            m4inv_pkg::OP_DIV_PRE: begin
                big_reg <= rem_ge;
                ds_reg  <= ds_reg >> 1;
            end
            m4inv_pkg::OP_DIV_STEP: begin
                if (rem_ge) begin
                    rem_reg <= rem_reg - ds_reg;
                end
                q_reg  <= {q_reg[QW-2:0], rem_ge};
                ds_reg <= ds_reg >> 1;
            end
            m4inv_pkg::OP_DIV_FIN: begin
                out_row      <= cmd.out_idx[3:2];
                out_col      <= cmd.out_idx[1:0];
                out_last     <= (cmd.out_idx == 4'd15);
                out_singular <= sing_reg;
                if (sing_reg) begin
                    out_value     <= '0;
                    out_saturated <= 1'b0;
                end else begin
                    out_value     <= div_neg ? (~res_mag + 1'b1) : res_mag;
                    out_saturated <= clip;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire
